// ===== rtl/scc_pkg.sv =====
// Shared types, constants and command/status structs of the sector cache policy engine.
package scc_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int SECTOR_BITS_DEF = 32;
  localparam int MAX_RESULTS     = 64;
  localparam int KIND_W          = 2;
  localparam int SECTOR_W        = 32;
  localparam int SLOT_W          = 6;
  localparam int WBC_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_FLUSH,
    ST_FL_EMIT,
    ST_FL_DONE,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_ZERO,
    CNT_HAND
  } cnt_op_t;

  typedef enum logic [2:0] {
    FLAG_NONE,
    FLAG_CLEAR,
    FLAG_TOUCH,
    FLAG_UNREF,
    FLAG_VICTIM,
    FLAG_CLEAN
  } flag_op_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_HIT,
    OUT_MISS,
    OUT_FLUSH,
    OUT_NULL,
    OUT_SET_LAST
  } out_op_t;

  typedef struct packed {
    logic     in_ld;
    cnt_op_t  cnt_op;
    flag_op_t flag_op;
    logic     tag_we;
    logic     hand_ld;
    out_op_t  out_op;
    logic     wb_cnt_clr;
    logic     wb_cnt_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic ent_valid;
    logic ent_dirty;
    logic ent_refd;
    logic tag_match;
    logic cnt_last;
    logic wb_cnt_full;
  } dp_stat_t;

endpackage

// ===== rtl/scc_dp.sv =====
// Datapath: entry flag and tag memories, scan counter, clock hand and result registers.
module scc_dp #(
  parameter int ENTRIES     = scc_pkg::ENTRIES_DEF,
  parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scc_pkg::dp_cmd_t            cmd,
  output scc_pkg::dp_stat_t           stat,
  input  logic [scc_pkg::KIND_W-1:0]  in_kind,
  input  logic [scc_pkg::SECTOR_W-1:0] in_sector,
  output logic [scc_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_hit,
  output logic                        out_write_back,
  output logic [scc_pkg::SECTOR_W-1:0] out_write_back_sector,
  output logic                        out_fill,
  output logic                        out_last
);

  localparam int IW = $clog2(ENTRIES);

  typedef struct packed {
    logic valid;
    logic dirty;
    logic refd;
  } flag_t;

  flag_t                      flag_mem [ENTRIES];
  logic [SECTOR_BITS-1:0]     tag_mem  [ENTRIES];

  flag_t                      flag_rd_r;
  flag_t                      flag_wd;
  logic                       flag_we;
  logic [SECTOR_BITS-1:0]     tag_rd_r;

  logic [IW-1:0]              cnt_r, cnt_nxt, cnt_inc;
  logic [IW-1:0]              hand_r;
  logic [scc_pkg::WBC_W-1:0]  wb_cnt_r;
  logic [SECTOR_BITS-1:0]     sector_r;
  logic                       write_r;

  logic [scc_pkg::SLOT_W-1:0]   slot_r;
  logic                         hit_r, wb_r, fill_r, last_r;
  logic [scc_pkg::SECTOR_W-1:0] wbs_r;

  assign cnt_inc = (cnt_r == IW'(ENTRIES - 1)) ? '0 : cnt_r + 1'b1;

  always_comb begin
    unique case (cmd.cnt_op)
      scc_pkg::CNT_HOLD: cnt_nxt = cnt_r;
      scc_pkg::CNT_INC:  cnt_nxt = cnt_inc;
      scc_pkg::CNT_ZERO: cnt_nxt = '0;
      scc_pkg::CNT_HAND: cnt_nxt = hand_r;
    endcase
  end

  always_comb begin
    flag_we = 1'b1;
    flag_wd = flag_rd_r;
    unique case (cmd.flag_op)
      scc_pkg::FLAG_CLEAR:  flag_wd = '0;
      scc_pkg::FLAG_TOUCH:  flag_wd = '{valid: 1'b1, dirty: flag_rd_r.dirty | write_r,
                                        refd: 1'b1};
      scc_pkg::FLAG_UNREF:  flag_wd.refd = 1'b0;
      scc_pkg::FLAG_VICTIM: flag_wd = '{valid: 1'b1, dirty: write_r, refd: 1'b1};
      scc_pkg::FLAG_CLEAN:  flag_wd.dirty = 1'b0;
      default:              flag_we = 1'b0;
    endcase
  end

  // write at the scan position, read the next one; a same-address write bypasses
  // so flag_rd_r/tag_rd_r always mirror the entry at cnt_r
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[cnt_r] <= flag_wd;
    end
    if (flag_we && (cnt_r == cnt_nxt)) begin
      flag_rd_r <= flag_wd;
    end else begin
      flag_rd_r <= flag_mem[cnt_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag_we) begin
      tag_mem[cnt_r] <= sector_r;
    end
    if (cmd.tag_we && (cnt_r == cnt_nxt)) begin
      tag_rd_r <= sector_r;
    end else begin
      tag_rd_r <= tag_mem[cnt_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      hand_r   <= '0;
      wb_cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.hand_ld) begin
        hand_r <= cnt_inc;
      end
      if (cmd.wb_cnt_clr) begin
        wb_cnt_r <= '0;
      end else if (cmd.wb_cnt_inc) begin
        wb_cnt_r <= wb_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      sector_r <= SECTOR_BITS'(in_sector);
      write_r  <= (in_kind == scc_pkg::KIND_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.out_op)
      scc_pkg::OUT_HIT: begin
        slot_r <= scc_pkg::SLOT_W'(cnt_r);
        hit_r  <= 1'b1;
        wb_r   <= 1'b0;
        wbs_r  <= '0;
        fill_r <= 1'b0;
        last_r <= 1'b1;
      end
      scc_pkg::OUT_MISS: begin
        slot_r <= scc_pkg::SLOT_W'(cnt_r);
        hit_r  <= 1'b0;
        wb_r   <= flag_rd_r.valid & flag_rd_r.dirty;
        wbs_r  <= (flag_rd_r.valid & flag_rd_r.dirty) ? scc_pkg::SECTOR_W'(tag_rd_r) : '0;
        fill_r <= 1'b1;
        last_r <= 1'b1;
      end
      scc_pkg::OUT_FLUSH: begin
        slot_r <= scc_pkg::SLOT_W'(cnt_r);
        hit_r  <= 1'b0;
        wb_r   <= 1'b1;
        wbs_r  <= scc_pkg::SECTOR_W'(tag_rd_r);
        fill_r <= 1'b0;
        last_r <= 1'b0;
      end
      scc_pkg::OUT_NULL: begin
        slot_r <= '0;
        hit_r  <= 1'b0;
        wb_r   <= 1'b0;
        wbs_r  <= '0;
        fill_r <= 1'b0;
        last_r <= 1'b1;
      end
      scc_pkg::OUT_SET_LAST: last_r <= 1'b1;
      default: ;
    endcase
  end

  assign stat.ent_valid   = flag_rd_r.valid;
  assign stat.ent_dirty   = flag_rd_r.dirty;
  assign stat.ent_refd    = flag_rd_r.refd;
  assign stat.tag_match   = (tag_rd_r == sector_r);
  assign stat.cnt_last    = (cnt_r == IW'(ENTRIES - 1));
  assign stat.wb_cnt_full = (wb_cnt_r == scc_pkg::WBC_W'(scc_pkg::MAX_RESULTS - 1));

  assign out_slot              = slot_r;
  assign out_hit               = hit_r;
  assign out_write_back        = wb_r;
  assign out_write_back_sector = wbs_r;
  assign out_fill              = fill_r;
  assign out_last              = last_r;

endmodule

// ===== rtl/scc_ctrl.sv =====
// Controller: state machine sequencing clear, lookup, clock sweep and flush scans.
module scc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [scc_pkg::KIND_W-1:0] in_kind,
  output logic                       out_valid,
  input  logic                       out_ready,
  output scc_pkg::dp_cmd_t           cmd,
  input  scc_pkg::dp_stat_t          stat
);

  scc_pkg::state_t state_r, state_nxt;
  logic            held_r, held_nxt;
  logic            found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::ST_CLEAR;
      held_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  assign found = stat.ent_valid & stat.ent_dirty;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    cmd       = '{in_ld: 1'b0, cnt_op: scc_pkg::CNT_HOLD, flag_op: scc_pkg::FLAG_NONE,
                  tag_we: 1'b0, hand_ld: 1'b0, out_op: scc_pkg::OUT_NONE,
                  wb_cnt_clr: 1'b0, wb_cnt_inc: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      scc_pkg::ST_CLEAR: begin
        cmd.flag_op = scc_pkg::FLAG_CLEAR;
        cmd.cnt_op  = scc_pkg::CNT_INC;
        if (stat.cnt_last) begin
          state_nxt = scc_pkg::ST_IDLE;
        end
      end
      scc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.cnt_op = scc_pkg::CNT_ZERO;
        if (in_valid) begin
          cmd.in_ld = 1'b1;
          case (in_kind) inside
            scc_pkg::KIND_READ, scc_pkg::KIND_WRITE: state_nxt = scc_pkg::ST_LOOKUP;
            scc_pkg::KIND_FLUSH: begin
              cmd.wb_cnt_clr = 1'b1;
              held_nxt       = 1'b0;
              state_nxt      = scc_pkg::ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      scc_pkg::ST_LOOKUP: begin
        if (stat.ent_valid && stat.tag_match) begin
          cmd.flag_op = scc_pkg::FLAG_TOUCH;
          cmd.out_op  = scc_pkg::OUT_HIT;
          cmd.cnt_op  = scc_pkg::CNT_ZERO;
          state_nxt   = scc_pkg::ST_RESULT;
        end else if (stat.cnt_last) begin
          cmd.cnt_op = scc_pkg::CNT_HAND;
          state_nxt  = scc_pkg::ST_SWEEP;
        end else begin
          cmd.cnt_op = scc_pkg::CNT_INC;
        end
      end
      scc_pkg::ST_SWEEP: begin
        // second chance: referenced entries lose their bit and are passed
        if (stat.ent_valid && stat.ent_refd) begin
          cmd.flag_op = scc_pkg::FLAG_UNREF;
          cmd.cnt_op  = scc_pkg::CNT_INC;
        end else begin
          cmd.flag_op = scc_pkg::FLAG_VICTIM;
          cmd.tag_we  = 1'b1;
          cmd.hand_ld = 1'b1;
          cmd.out_op  = scc_pkg::OUT_MISS;
          cmd.cnt_op  = scc_pkg::CNT_ZERO;
          state_nxt   = scc_pkg::ST_RESULT;
        end
      end
      scc_pkg::ST_FLUSH: begin
        // one write-back is held back until we know whether it is the last
        if (found && held_r) begin
          state_nxt = scc_pkg::ST_FL_EMIT;
        end else begin
          if (found) begin
            cmd.flag_op    = scc_pkg::FLAG_CLEAN;
            cmd.out_op     = scc_pkg::OUT_FLUSH;
            cmd.wb_cnt_inc = 1'b1;
            held_nxt       = 1'b1;
          end
          if (stat.cnt_last || (found && stat.wb_cnt_full)) begin
            cmd.cnt_op = scc_pkg::CNT_ZERO;
            state_nxt  = scc_pkg::ST_FL_DONE;
          end else begin
            cmd.cnt_op = scc_pkg::CNT_INC;
          end
        end
      end
      scc_pkg::ST_FL_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          held_nxt  = 1'b0;
          state_nxt = scc_pkg::ST_FLUSH;
        end
      end
      scc_pkg::ST_FL_DONE: begin
        cmd.out_op = held_r ? scc_pkg::OUT_SET_LAST : scc_pkg::OUT_NULL;
        held_nxt   = 1'b0;
        state_nxt  = scc_pkg::ST_RESULT;
      end
      scc_pkg::ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = scc_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== rtl/sector_cache_clock_policy.sv =====
// Top level of the fully associative write-back sector cache tag and clock policy engine.
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_ready  | in_kind, in_sector
//   out_    | result    | out_valid / out_ready| out_slot, out_hit, out_write_back,
//           |           |                      | out_write_back_sector, out_fill, out_last
//
// After reset the entry flags are cleared one entry a cycle, with in_ready low. Read/write: a tag
// lookup scans one entry a cycle from slot 0 up to a hit; a miss adds a clock sweep from the hand
// that unmarks referenced entries up to a victim. Flush: each write-back is held until the next is
// found and is then presented; the scan ends at the last entry or at MAX_RESULTS write-backs, and
// the final result is marked last (or a null one is given). The scan waits while a result is presented.
// One request is in flight at a time; a stalled result holds the engine until taken.
module sector_cache_clock_policy #(
  parameter int ENTRIES     = scc_pkg::ENTRIES_DEF,
  parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scc_pkg::KIND_W-1:0]   in_kind,
  input  logic [scc_pkg::SECTOR_W-1:0] in_sector,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scc_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_hit,
  output logic                         out_write_back,
  output logic [scc_pkg::SECTOR_W-1:0] out_write_back_sector,
  output logic                         out_fill,
  output logic                         out_last
);

  scc_pkg::dp_cmd_t  cmd;
  scc_pkg::dp_stat_t stat;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  scc_dp #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_kind               (in_kind),
    .in_sector             (in_sector),
    .out_slot              (out_slot),
    .out_hit               (out_hit),
    .out_write_back        (out_write_back),
    .out_write_back_sector (out_write_back_sector),
    .out_fill              (out_fill),
    .out_last              (out_last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && (out_fill || out_write_back)))
    else $error("hit result carries fill or write-back");

  a_mid_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_write_back && !out_hit && !out_fill))
    else $error("non-final result is not a flush write-back");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("engine not idle after final result");

endmodule
